>>> rtl/core/lms_pkg.sv
// Shared types and fixed-point constants of the LMS adaptive FIR filter.
`timescale 1ns / 1ps

package lms_pkg;

  localparam int unsigned SAMPLE_W = 16;  // Q1.15 samples and results
  localparam int unsigned COEF_W   = 32;  // Q4.28 coefficients
  localparam int unsigned STEP_W   = 16;  // unsigned Q0.16 step size

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd328;

  // Fraction bits dropped when reducing the filter sum and the update term.
  localparam int unsigned ACC_FRAC = 28;
  localparam int unsigned UPD_FRAC = 18;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic        [STEP_W-1:0]   step_t;

endpackage

>>> rtl/core/lms_if.sv
// Valid/ready channels of the LMS filter: input samples, results, step size.
`timescale 1ns / 1ps

interface lms_in_if import lms_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t x_sample;
  sample_t desired_sample;

  modport source (output valid, output x_sample, output desired_sample, input ready);
  modport sink   (input valid, input x_sample, input desired_sample, output ready);
endinterface

interface lms_out_if import lms_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t filter_out;
  sample_t error_out;

  modport source (output valid, output filter_out, output error_out, input ready);
  modport sink   (input valid, input filter_out, input error_out, output ready);
endinterface

interface lms_cfg_if import lms_pkg::*; ();
  logic  valid;
  logic  ready;
  step_t step_size;

  modport source (output valid, output step_size, input ready);
  modport sink   (input valid, input step_size, output ready);
endinterface

>>> rtl/core/lms_adaptive_fir.sv
// Top level of the LMS adaptive FIR filter with one shared multiply unit.
`timescale 1ns / 1ps

// LMS adaptive FIR filter. Each input beat carries one Q1.15 input sample and
// one Q1.15 desired sample; each produces one result beat with the filter
// output y (taken with the coefficients before adaptation) and the error
// e = d - y, both saturated to Q1.15. The block works on one beat at a time:
// in_ch.ready is high only while idle, and a beat occupies the block until
// its coefficient update pass is done; only then can the next one be taken.
// The block has a single 33x17 multiplier behind a two-stage read/multiply
// pipeline, which makes one pass over the taps for the dot product and a
// second pass for the coefficient update; between the passes it rounds the
// sum, saturates, forms the error and scales it by the step size. The result
// beat is offered once the error is formed and sits in an output register,
// so the update pass runs while the sink holds off. The delay line is a
// circular buffer and the coefficients a plain memory, each with one valid
// bit per entry so that reset empties both at once. step_size (unsigned
// Q0.16, reset 328) is written over cfg_ch, which is always ready; write it
// only while the block is idle.
module lms_adaptive_fir import lms_pkg::*; #(
  parameter int unsigned TAPS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lms_in_if.sink    in_ch,
  lms_out_if.source out_ch,
  lms_cfg_if.sink   cfg_ch
);

  localparam int unsigned IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned ACC_W = MUL_P_W + IDX_W;
  localparam int unsigned Y_W   = ACC_W - ACC_FRAC;
  localparam int unsigned D_W   = Y_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);

  localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(32767);
  localparam logic signed [Y_W-1:0] Y_MIN = -Y_W'(32768);
  localparam logic signed [D_W-1:0] D_MAX = D_W'(32767);
  localparam logic signed [D_W-1:0] D_MIN = -D_W'(32768);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for an input beat
  localparam logic [2:0] ST_MAC  = 3'd1;  // dot-product pass
  localparam logic [2:0] ST_RND  = 3'd2;  // round the sum to Q.15
  localparam logic [2:0] ST_ERR  = 3'd3;  // saturate, form error, load result
  localparam logic [2:0] ST_MUE  = 3'd4;  // multiply step size by error
  localparam logic [2:0] ST_LDM  = 3'd5;  // latch the scaled error
  localparam logic [2:0] ST_UPD  = 3'd6;  // coefficient update pass

  logic [2:0] state_q, state_d;

  // Configuration
  step_t step_q;

  // Storage
  sample_t     x_mem [TAPS];
  coef_t       c_mem [TAPS];
  logic [TAPS-1:0] x_vld_q;
  logic [TAPS-1:0] c_vld_q;

  logic [IDX_W-1:0] wp_q, wp_inc;   // newest sample position
  logic [IDX_W-1:0] xp_q;           // delay line read position
  logic [IDX_W-1:0] cnt_q;          // tap index being issued
  logic             issue_q;

  // Pipeline: read stage then multiply stage
  logic             s1_vld_q, s2_vld_q;
  logic [IDX_W-1:0] s1_idx_q, s2_idx_q;
  sample_t          x_rd_q;
  coef_t            c_rd_q;
  logic             x_rv_q, c_rv_q;
  coef_t            c_pipe_q;

  sample_t x_op;
  coef_t   c_op;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_q;

  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [Y_W-1:0]     y_q;
  sample_t                   d_q;
  sample_t                   e_q;
  logic signed [MUL_A_W-1:0] mu_e_q;

  sample_t                  ys;
  logic signed [D_W-1:0]    diff;
  sample_t                  e_sat;

  logic signed [MUL_P_W-1:0] upd_rnd;
  coef_t                     delta;
  logic signed [COEF_W:0]    c_sum;
  coef_t                     c_new;

  logic    out_vld_q;
  sample_t out_y_q, out_e_q;

  logic in_fire, out_free, pass_done;

  assign in_ch.ready   = (state_q == ST_IDLE);
  assign in_fire       = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid      = out_vld_q;
  assign out_ch.filter_out = out_y_q;
  assign out_ch.error_out  = out_e_q;
  assign out_free      = ~out_vld_q | out_ch.ready;
  assign pass_done     = ~issue_q & ~s1_vld_q;

  assign wp_inc = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_MAC;
      ST_MAC:  if (pass_done) state_d = ST_RND;
      ST_RND:  state_d = ST_ERR;
      ST_ERR:  if (out_free) state_d = ST_MUE;
      ST_MUE:  state_d = ST_LDM;
      ST_LDM:  state_d = ST_UPD;
      ST_UPD:  if (pass_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= STEP_RESET;
      wp_q      <= '0;
      xp_q      <= '0;
      cnt_q     <= '0;
      issue_q   <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      x_vld_q   <= '0;
      c_vld_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= issue_q;
      s2_vld_q <= s1_vld_q;
      if (cfg_ch.valid) begin
        step_q <= cfg_ch.step_size;
      end
      if (in_fire) begin
        wp_q    <= wp_inc;
        xp_q    <= wp_inc;
        cnt_q   <= '0;
        issue_q <= 1'b1;
        x_vld_q[wp_inc] <= 1'b1;
      end else if (state_q == ST_LDM) begin
        xp_q    <= wp_q;
        cnt_q   <= '0;
        issue_q <= 1'b1;
      end else if (issue_q) begin
        xp_q  <= (xp_q == '0) ? LAST_IDX : xp_q - 1'b1;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          issue_q <= 1'b0;
        end
      end
      if (state_q == ST_UPD && s2_vld_q) begin
        c_vld_q[s2_idx_q] <= 1'b1;
      end
      if (state_q == ST_ERR && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Delay line memory: newest sample goes one past the previous newest
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_mem[wp_inc] <= in_ch.x_sample;
    end
    x_rd_q <= x_mem[xp_q];
    x_rv_q <= x_vld_q[xp_q];
  end

  // Coefficient memory: written back from the end of the update pipeline
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD && s2_vld_q) begin
      c_mem[s2_idx_q] <= c_new;
    end
    c_rd_q <= c_mem[cnt_q];
    c_rv_q <= c_vld_q[cnt_q];
  end

  // Entries never written read as zero
  assign x_op = x_rv_q ? x_rd_q : '0;
  assign c_op = c_rv_q ? c_rd_q : '0;

  // Shared multiplier operand select
  always_comb begin
    case (state_q)
      ST_MAC: begin
        mul_a = {c_op[COEF_W-1], c_op};
        mul_b = {x_op[SAMPLE_W-1], x_op};
      end
      ST_MUE: begin
        mul_a = {{(MUL_A_W-STEP_W){1'b0}}, step_q};
        mul_b = {e_q[SAMPLE_W-1], e_q};
      end
      default: begin
        mul_a = mu_e_q;
        mul_b = {x_op[SAMPLE_W-1], x_op};
      end
    endcase
  end

  // Reduce the sum: add half an LSB, floor-shift by the fraction bits
  assign acc_rnd = acc_q + ACC_W'(64'd1 << (ACC_FRAC - 1));

  // Saturate y, form and saturate the error from the unsaturated y
  always_comb begin
    if (y_q > Y_MAX) begin
      ys = 16'sh7FFF;
    end else if (y_q < Y_MIN) begin
      ys = 16'sh8000;
    end else begin
      ys = y_q[SAMPLE_W-1:0];
    end
    diff = {{(D_W-SAMPLE_W){d_q[SAMPLE_W-1]}}, d_q} - {y_q[Y_W-1], y_q};
    if (diff > D_MAX) begin
      e_sat = 16'sh7FFF;
    end else if (diff < D_MIN) begin
      e_sat = 16'sh8000;
    end else begin
      e_sat = diff[SAMPLE_W-1:0];
    end
  end

  // Update term rounded to Q4.28, added and clamped to the coefficient range
  assign upd_rnd = mul_q + MUL_P_W'(64'd1 << (UPD_FRAC - 1));
  assign delta   = upd_rnd[UPD_FRAC +: COEF_W];
  assign c_sum   = {c_pipe_q[COEF_W-1], c_pipe_q} + {delta[COEF_W-1], delta};
  always_comb begin
    if (c_sum[COEF_W] != c_sum[COEF_W-1]) begin
      c_new = c_sum[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      c_new = c_sum[COEF_W-1:0];
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mul_q    <= mul_a * mul_b;
    c_pipe_q <= c_op;
    s1_idx_q <= cnt_q;
    s2_idx_q <= s1_idx_q;
    if (in_fire) begin
      d_q   <= in_ch.desired_sample;
      acc_q <= '0;
    end else if (state_q == ST_MAC && s2_vld_q) begin
      acc_q <= acc_q + {{IDX_W{mul_q[MUL_P_W-1]}}, mul_q};
    end
    if (state_q == ST_RND) begin
      y_q <= acc_rnd[ACC_W-1:ACC_FRAC];
    end
    if (state_q == ST_ERR && out_free) begin
      e_q     <= e_sat;
      out_y_q <= ys;
      out_e_q <= e_sat;
    end
    if (state_q == ST_LDM) begin
      mu_e_q <= mul_q[MUL_A_W-1:0];
    end
  end

endmodule
